[design/rasp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rasp_pkg
// Shared widths, codes and types for the array-of-bulk-strings log parser.
// ----------------------------------------------------------------------------
package rasp_pkg;

  // field and counter widths
  localparam int COUNT_BITS  = 14;
  localparam int LENGTH_BITS = 21;
  localparam int ACC_BITS    = (COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS;
  // accumulator holds values up to 2^ACC_BITS (saturation point)
  localparam int ACC_W       = ACC_BITS + 1;
  localparam int PROD_W      = ACC_W + 4;

  localparam int BYTE_BITS   = 8;
  localparam int KIND_BITS   = 3;
  localparam int CODE_BITS   = 3;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = ACC_BITS;

  // register reset values
  localparam logic [COUNT_BITS-1:0]  MAX_ARG_COUNT_RST  = COUNT_BITS'(10000);
  localparam logic [LENGTH_BITS-1:0] MAX_ARG_LENGTH_RST = LENGTH_BITS'(1048576);

  // saturation value of the decimal accumulator
  localparam logic [ACC_W-1:0] ACC_CAP = {1'b1, {ACC_BITS{1'b0}}};

  // special bytes
  localparam logic [BYTE_BITS-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_BITS-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_BITS-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_BITS-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_BITS-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_BITS-1:0] CH_NINE   = 8'h39;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MAX_ARG_COUNT  = 1'b0,
    REG_MAX_ARG_LENGTH = 1'b1
  } rasp_reg_t;

  // parser phases
  typedef enum logic [3:0] {
    PH_START     = 4'd0,
    PH_BLANK_LF  = 4'd1,
    PH_COUNT     = 4'd2,
    PH_COUNT_LF  = 4'd3,
    PH_BULK_MARK = 4'd4,
    PH_LEN       = 4'd5,
    PH_LEN_LF    = 4'd6,
    PH_PAYLOAD   = 4'd7,
    PH_TERM_CR   = 4'd8,
    PH_TERM_LF   = 4'd9,
    PH_HALTED    = 4'd10,
    PH_ERROR     = 4'd11
  } rasp_phase_t;

  // result kinds
  typedef enum logic [KIND_BITS-1:0] {
    K_FRAME   = 3'd0,
    K_PAYLOAD = 3'd1,
    K_ARG_END = 3'd2,
    K_HALT    = 3'd3,
    K_ERROR   = 3'd4
  } rasp_kind_t;

  // error codes
  typedef enum logic [CODE_BITS-1:0] {
    E_NONE        = 3'd0,
    E_BAD_RECORD  = 3'd1,
    E_BAD_COUNT   = 3'd2,
    E_BAD_BULK    = 3'd3,
    E_BAD_LENGTH  = 3'd4,
    E_BAD_TERM    = 3'd5
  } rasp_err_t;

  // configured limits, register block to parser core
  typedef struct packed {
    logic [COUNT_BITS-1:0]  max_arg_count;
    logic [LENGTH_BITS-1:0] max_arg_length;
  } rasp_limits_t;

  // one result beat
  typedef struct packed {
    rasp_kind_t             result_kind;
    logic [BYTE_BITS-1:0]   payload_byte;
    logic [COUNT_BITS-1:0]  arg_index;
    logic                   record_end;
    rasp_err_t              error_code;
  } rasp_result_t;

endpackage

[design/rasp_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rasp channel interfaces
// Valid/ready channels for input bytes, results and register writes.
// ----------------------------------------------------------------------------

// input byte channel
interface rasp_in_if;
  import rasp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// result channel
interface rasp_out_if;
  import rasp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [KIND_BITS-1:0]  result_kind;
  logic [BYTE_BITS-1:0]  payload_byte;
  logic [COUNT_BITS-1:0] arg_index;
  logic                  record_end;
  logic [CODE_BITS-1:0]  error_code;

  modport source (output valid, output result_kind, output payload_byte,
                  output arg_index, output record_end, output error_code,
                  input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input arg_index, input record_end, input error_code,
                  output ready);
endinterface

// register write channel
interface rasp_cfg_if;
  import rasp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/rasp_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rasp_cfg_regs
// Count and length limit registers, written through the register channel.
// ----------------------------------------------------------------------------
module rasp_cfg_regs (
  input  logic                  clk,
  input  logic                  rst,
  rasp_cfg_if.sink              cfg,
  output rasp_pkg::rasp_limits_t limits
);
  import rasp_pkg::*;

  logic [COUNT_BITS-1:0]  max_arg_count;
  logic [LENGTH_BITS-1:0] max_arg_length;

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register write on each beat
  always_ff @(posedge clk) begin
    if (rst) begin
      max_arg_count  <= MAX_ARG_COUNT_RST;
      max_arg_length <= MAX_ARG_LENGTH_RST;
    end else if (cfg.valid) begin
      case (rasp_reg_t'(cfg.index))
        REG_MAX_ARG_COUNT:  max_arg_count  <= cfg.data[COUNT_BITS-1:0];
        REG_MAX_ARG_LENGTH: max_arg_length <= cfg.data[LENGTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign limits.max_arg_count  = max_arg_count;
  assign limits.max_arg_length = max_arg_length;

endmodule

[design/rasp_parse_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rasp_parse_core
// Parser state and the single-step transition for one byte.
// ----------------------------------------------------------------------------
module rasp_parse_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [rasp_pkg::BYTE_BITS-1:0] data_byte,
  input  rasp_pkg::rasp_limits_t       limits,
  output rasp_pkg::rasp_result_t       result
);
  import rasp_pkg::*;

  rasp_phase_t            phase, phase_next;
  rasp_err_t              err_code, err_next;
  logic [ACC_W-1:0]       acc, acc_next;
  logic                   digit_seen, digit_seen_next;
  logic [COUNT_BITS-1:0]  elems_left, elems_left_next;
  logic [COUNT_BITS-1:0]  elem_idx, elem_idx_next;
  logic [LENGTH_BITS-1:0] payload_left, payload_left_next;

  logic                   is_digit, is_cr, is_lf, is_star, is_dollar;
  logic                   count_ok, length_ok, last_elem;
  logic [PROD_W-1:0]      acc_prod;
  logic [ACC_W-1:0]       acc_sat;

  // byte classes
  assign is_digit  = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign is_cr     = (data_byte == CH_CR);
  assign is_lf     = (data_byte == CH_LF);
  assign is_star   = (data_byte == CH_STAR);
  assign is_dollar = (data_byte == CH_DOLLAR);

  // decimal accumulate: acc * 10 + digit, saturating
  assign acc_prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                  + PROD_W'(data_byte - CH_ZERO);
  assign acc_sat  = (acc_prod > PROD_W'(ACC_CAP)) ? ACC_CAP : acc_prod[ACC_W-1:0];

  // number checks
  assign count_ok  = digit_seen && (acc != '0) && (acc <= ACC_W'(limits.max_arg_count));
  assign length_ok = digit_seen && (acc <= ACC_W'(limits.max_arg_length));
  assign last_elem = (elems_left <= COUNT_BITS'(1));

  // next phase and error capture
  always_comb begin
    phase_next = phase;
    err_next   = err_code;
    case (phase)
      PH_START: begin
        if (is_star)      phase_next = PH_COUNT;
        else if (is_cr)   phase_next = PH_BLANK_LF;
        else if (is_lf)   phase_next = PH_HALTED;
        else begin
          phase_next = PH_ERROR;
          err_next   = E_BAD_RECORD;
        end
      end
      PH_BLANK_LF: begin
        if (is_lf) phase_next = PH_START;
        else begin
          phase_next = PH_ERROR;
          err_next   = E_BAD_RECORD;
        end
      end
      PH_COUNT, PH_COUNT_LF: begin
        if (phase == PH_COUNT && is_digit) phase_next = PH_COUNT;
        else if (phase == PH_COUNT && is_cr) phase_next = PH_COUNT_LF;
        else if (is_lf && count_ok) phase_next = PH_BULK_MARK;
        else begin
          phase_next = PH_ERROR;
          err_next   = E_BAD_COUNT;
        end
      end
      PH_BULK_MARK: begin
        if (is_dollar) phase_next = PH_LEN;
        else begin
          phase_next = PH_ERROR;
          err_next   = E_BAD_BULK;
        end
      end
      PH_LEN, PH_LEN_LF: begin
        if (phase == PH_LEN && is_digit) phase_next = PH_LEN;
        else if (phase == PH_LEN && is_cr) phase_next = PH_LEN_LF;
        else if (is_lf && length_ok) begin
          phase_next = (acc == '0) ? PH_TERM_CR : PH_PAYLOAD;
        end else begin
          phase_next = PH_ERROR;
          err_next   = E_BAD_LENGTH;
        end
      end
      PH_PAYLOAD: begin
        if (payload_left == LENGTH_BITS'(1)) phase_next = PH_TERM_CR;
      end
      PH_TERM_CR: begin
        if (is_cr) phase_next = PH_TERM_LF;
        else begin
          phase_next = PH_ERROR;
          err_next   = E_BAD_TERM;
        end
      end
      PH_TERM_LF: begin
        if (is_lf) phase_next = last_elem ? PH_START : PH_BULK_MARK;
        else begin
          phase_next = PH_ERROR;
          err_next   = E_BAD_TERM;
        end
      end
      PH_HALTED: phase_next = PH_HALTED;
      default:   phase_next = PH_ERROR;
    endcase
  end

  // counters and accumulator
  always_comb begin
    acc_next          = acc;
    digit_seen_next   = digit_seen;
    elems_left_next   = elems_left;
    elem_idx_next     = elem_idx;
    payload_left_next = payload_left;
    case (phase)
      PH_START, PH_BULK_MARK: begin
        acc_next        = '0;
        digit_seen_next = 1'b0;
      end
      PH_COUNT, PH_COUNT_LF: begin
        if (phase == PH_COUNT && is_digit) begin
          acc_next        = acc_sat;
          digit_seen_next = 1'b1;
        end else if (is_lf) begin
          elems_left_next = acc[COUNT_BITS-1:0];
          elem_idx_next   = '0;
        end
      end
      PH_LEN, PH_LEN_LF: begin
        if (phase == PH_LEN && is_digit) begin
          acc_next        = acc_sat;
          digit_seen_next = 1'b1;
        end else if (is_lf) begin
          payload_left_next = acc[LENGTH_BITS-1:0];
        end
      end
      PH_PAYLOAD: payload_left_next = payload_left - LENGTH_BITS'(1);
      PH_TERM_LF: begin
        if (is_lf) begin
          if (last_elem) begin
            elems_left_next = '0;
            elem_idx_next   = '0;
          end else begin
            elems_left_next = elems_left - COUNT_BITS'(1);
            elem_idx_next   = elem_idx + COUNT_BITS'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // result for this byte
  always_comb begin
    result.result_kind  = K_FRAME;
    result.payload_byte = '0;
    result.arg_index    = '0;
    result.record_end   = 1'b0;
    result.error_code   = E_NONE;
    case (phase_next)
      PH_ERROR: begin
        result.result_kind = K_ERROR;
        result.error_code  = err_next;
      end
      PH_HALTED: result.result_kind = K_HALT;
      default: begin
        if (phase == PH_PAYLOAD) begin
          result.result_kind  = K_PAYLOAD;
          result.payload_byte = data_byte;
          result.arg_index    = elem_idx;
        end else if (phase == PH_TERM_LF) begin
          result.result_kind = K_ARG_END;
          result.arg_index   = elem_idx;
          result.record_end  = last_elem;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      err_code <= E_NONE;
    end else if (step) begin
      phase    <= phase_next;
      err_code <= err_next;
    end
  end

  // datapath state
  always_ff @(posedge clk) begin
    if (step) begin
      acc          <= acc_next;
      digit_seen   <= digit_seen_next;
      elems_left   <= elems_left_next;
      elem_idx     <= elem_idx_next;
      payload_left <= payload_left_next;
    end
  end

endmodule

[design/resp_array_stream_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_array_stream_parser_top
// Parses "*N" records of N "$L" bulk strings from a byte stream, one result
// beat per input byte, with configurable count and length limits.
// ----------------------------------------------------------------------------
//  channel | role   | payload
//  --------+--------+-----------------------------------------------------
//  din     | sink   | data_byte
//  dout    | source | result_kind, payload_byte, arg_index, record_end,
//          |        | error_code
//  cfg     | sink   | index (0 max_arg_count, 1 max_arg_length), data
//
//  One byte per cycle sustained while dout is ready; each byte's result reaches
//  dout through the input register, then the result register after the parse
//  step. The parse step is combinational between these two registers, so
//  bytes flow back to back.
//  A stall on dout holds the result register and then the input register.
//  rst is synchronous; it restores the limits and returns to record start.
// ----------------------------------------------------------------------------
module resp_array_stream_parser_top (
  input  logic        clk,
  input  logic        rst,
  rasp_in_if.sink     din,
  rasp_out_if.source  dout,
  rasp_cfg_if.sink    cfg
);
  import rasp_pkg::*;

  rasp_limits_t         limits;
  rasp_result_t         core_res;
  rasp_result_t         res;
  logic                 res_valid;
  logic                 in_valid;
  logic [BYTE_BITS-1:0] in_byte;
  logic                 advance;
  logic                 step;

  // pipeline flow control
  assign advance   = !res_valid || dout.ready;
  assign step      = in_valid && advance;
  assign din.ready = !in_valid || step;

  rasp_cfg_regs u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .limits (limits)
  );

  rasp_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .limits    (limits),
    .result    (core_res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (din.valid && din.ready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      in_byte <= din.data_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (dout.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= core_res;
    end
  end

  // result beat
  assign dout.valid        = res_valid;
  assign dout.result_kind  = res.result_kind;
  assign dout.payload_byte = res.payload_byte;
  assign dout.arg_index    = res.arg_index;
  assign dout.record_end   = res.record_end;
  assign dout.error_code   = res.error_code;

endmodule

[bench/resp_array_stream_parser_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_array_stream_parser_checker
// Watches the byte, result and register channels of the log parser. Keeps
// its own copy of the parse state and limits, works out the result beat for
// every accepted byte and compares each result beat, field by field, with
// the oldest one still owed.
// ----------------------------------------------------------------------------
module resp_array_stream_parser_checker (
  input  logic clk,
  input  logic rst,
  rasp_in_if   din,
  rasp_out_if  dout,
  rasp_cfg_if  cfg,
  output int   fail_count,
  output int   results_owed,
  output int   beats_checked,
  output int   records_done
);
  import rasp_pkg::*;

  // limits as last written
  logic [COUNT_BITS-1:0]  lim_count;
  logic [LENGTH_BITS-1:0] lim_length;

  // shadow parse state
  rasp_phase_t            phase;
  logic [ACC_W-1:0]       num_acc;
  logic                   num_any;
  logic [COUNT_BITS-1:0]  elems_left;
  logic [COUNT_BITS-1:0]  elem_idx;
  logic [LENGTH_BITS-1:0] bytes_left;
  rasp_err_t              err_code;

  rasp_result_t owed_results[$];
  int mismatches;
  int checked;
  int records;
  int owed_now;

  assign fail_count    = mismatches;
  assign beats_checked = checked;
  assign records_done  = records;
  assign results_owed  = owed_now;

  function automatic rasp_result_t make_beat(input rasp_kind_t k,
                                             input logic [BYTE_BITS-1:0] pb,
                                             input logic [COUNT_BITS-1:0] idx,
                                             input logic last,
                                             input rasp_err_t c);
    rasp_result_t r;
    r.result_kind  = k;
    r.payload_byte = pb;
    r.arg_index    = idx;
    r.record_end   = last;
    r.error_code   = c;
    return r;
  endfunction

  function automatic rasp_result_t frame_beat();
    return make_beat(K_FRAME, '0, '0, 1'b0, E_NONE);
  endfunction

  // enter the sticky error state
  function automatic rasp_result_t latch_error(input rasp_err_t c);
    err_code = c;
    phase    = PH_ERROR;
    return make_beat(K_ERROR, '0, '0, 1'b0, c);
  endfunction

  // decimal accumulate with saturation at the cap
  function automatic void add_digit(input logic [BYTE_BITS-1:0] b);
    logic [PROD_W-1:0] prod;
    prod    = PROD_W'(num_acc) * PROD_W'(10) + PROD_W'(b - CH_ZERO);
    num_acc = (prod > PROD_W'(ACC_CAP)) ? ACC_CAP : prod[ACC_W-1:0];
    num_any = 1'b1;
  endfunction

  // count line done: range check, then first bulk header
  function automatic rasp_result_t close_count();
    if (!num_any || num_acc < 1 || num_acc > ACC_W'(lim_count)) begin
      return latch_error(E_BAD_COUNT);
    end
    elems_left = num_acc[COUNT_BITS-1:0];
    elem_idx   = '0;
    num_acc    = '0;
    num_any    = 1'b0;
    phase      = PH_BULK_MARK;
    return frame_beat();
  endfunction

  // length line done: range check, then payload or terminator
  function automatic rasp_result_t close_length();
    if (!num_any || num_acc > ACC_W'(lim_length)) begin
      return latch_error(E_BAD_LENGTH);
    end
    bytes_left = num_acc[LENGTH_BITS-1:0];
    num_acc    = '0;
    num_any    = 1'b0;
    phase      = (bytes_left == 0) ? PH_TERM_CR : PH_PAYLOAD;
    return frame_beat();
  endfunction

  // one parse step per accepted byte
  function automatic rasp_result_t parse_byte(input logic [BYTE_BITS-1:0] b);
    logic         is_digit;
    logic         last;
    rasp_result_t r;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    r = frame_beat();
    case (phase)
      PH_START: begin
        if (b == CH_STAR) begin
          num_acc = '0;
          num_any = 1'b0;
          phase   = PH_COUNT;
        end else if (b == CH_CR) begin
          phase = PH_BLANK_LF;
        end else if (b == CH_LF) begin
          phase = PH_HALTED;
          r = make_beat(K_HALT, '0, '0, 1'b0, E_NONE);
        end else begin
          r = latch_error(E_BAD_RECORD);
        end
      end
      PH_BLANK_LF: begin
        if (b == CH_LF) phase = PH_START;
        else r = latch_error(E_BAD_RECORD);
      end
      PH_COUNT: begin
        if (is_digit) add_digit(b);
        else if (b == CH_CR) phase = PH_COUNT_LF;
        else if (b == CH_LF) r = close_count();
        else r = latch_error(E_BAD_COUNT);
      end
      PH_COUNT_LF: begin
        if (b == CH_LF) r = close_count();
        else r = latch_error(E_BAD_COUNT);
      end
      PH_BULK_MARK: begin
        if (b == CH_DOLLAR) begin
          num_acc = '0;
          num_any = 1'b0;
          phase   = PH_LEN;
        end else begin
          r = latch_error(E_BAD_BULK);
        end
      end
      PH_LEN: begin
        if (is_digit) add_digit(b);
        else if (b == CH_CR) phase = PH_LEN_LF;
        else if (b == CH_LF) r = close_length();
        else r = latch_error(E_BAD_LENGTH);
      end
      PH_LEN_LF: begin
        if (b == CH_LF) r = close_length();
        else r = latch_error(E_BAD_LENGTH);
      end
      PH_PAYLOAD: begin
        r = make_beat(K_PAYLOAD, b, elem_idx, 1'b0, E_NONE);
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) phase = PH_TERM_CR;
      end
      PH_TERM_CR: begin
        if (b == CH_CR) phase = PH_TERM_LF;
        else r = latch_error(E_BAD_TERM);
      end
      PH_TERM_LF: begin
        if (b != CH_LF) begin
          r = latch_error(E_BAD_TERM);
        end else begin
          last = (elems_left <= 1);
          r = make_beat(K_ARG_END, '0, elem_idx, last, E_NONE);
          if (last) begin
            elems_left = '0;
            elem_idx   = '0;
            phase      = PH_START;
          end else begin
            elems_left = elems_left - 1'b1;
            elem_idx   = elem_idx + 1'b1;
            phase      = PH_BULK_MARK;
          end
        end
      end
      PH_HALTED: r = make_beat(K_HALT, '0, '0, 1'b0, E_NONE);
      default: begin
        phase = PH_ERROR;
        r = make_beat(K_ERROR, '0, '0, 1'b0, err_code);
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // pop-and-compare before pushing: a byte taken this edge cannot have
  // its result out yet
  always @(posedge clk) begin : watch
    rasp_result_t want;
    if (rst) begin
      lim_count  = MAX_ARG_COUNT_RST;
      lim_length = MAX_ARG_LENGTH_RST;
      phase      = PH_START;
      num_acc    = '0;
      num_any    = 1'b0;
      elems_left = '0;
      elem_idx   = '0;
      bytes_left = '0;
      err_code   = E_NONE;
      owed_results.delete();
      owed_now <= 0;
    end else begin
      // result beat
      if (dout.valid && dout.ready) begin
        checked++;
        if (dout.result_kind == K_ARG_END && dout.record_end) records++;
        if (owed_results.size() == 0) begin
          $display("%0t: result beat with none owed, expected nothing, actual kind %0d",
                   $time, dout.result_kind);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          check_field("result_kind", want.result_kind, dout.result_kind);
          check_field("payload_byte", want.payload_byte, dout.payload_byte);
          check_field("arg_index", want.arg_index, dout.arg_index);
          check_field("record_end", want.record_end, dout.record_end);
          check_field("error_code", want.error_code, dout.error_code);
        end
      end
      // register write
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_MAX_ARG_COUNT) lim_count = cfg.data[COUNT_BITS-1:0];
        else if (cfg.index == REG_MAX_ARG_LENGTH) lim_length = cfg.data[LENGTH_BITS-1:0];
      end
      // input beat
      if (din.valid && din.ready) owed_results.push_back(parse_byte(din.data_byte));
      owed_now <= owed_results.size();
    end
  end

endmodule

[bench/resp_array_stream_parser_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_array_stream_parser_top_tb
// Feeds the log parser a byte stream of well-formed array records with random
// payload, header styles, blank lines and limits, under random gaps and
// result stalls, then ends the stream with one randomly chosen halt or
// malformed sequence and a tail of noise. The checker does the comparing.
// ----------------------------------------------------------------------------
module resp_array_stream_parser_top_tb;
  import rasp_pkg::*;

  localparam int RANDOM_BYTES = 1800;
  localparam int PHASE_BYTES  = 250;
  localparam int CYCLE_LIMIT  = 300000;

  // ways the stream is ended
  typedef enum int {
    END_HALT, END_BAD_RECORD, END_BAD_BLANK, END_COUNT_ZERO, END_COUNT_OVER,
    END_COUNT_CHAR, END_COUNT_EMPTY, END_COUNT_CR, END_COUNT_SAT, END_BAD_BULK,
    END_LEN_OVER, END_LEN_CHAR, END_LEN_EMPTY, END_LEN_CR, END_LEN_SAT,
    END_TERM_CHAR, END_TERM_LF
  } ending_t;

  logic clk = 1'b0;
  logic rst;

  rasp_in_if  din ();
  rasp_out_if dout ();
  rasp_cfg_if cfg ();

  int fail_count;
  int results_owed;
  int beats_checked;
  int records_done;

  int          bytes_sent = 0;
  int          reg_writes = 0;
  int          cycles     = 0;
  int unsigned lim_cnt;
  int unsigned lim_len;
  bit          src_burst  = 1'b0;
  bit          snk_burst  = 1'b0;
  ending_t     stream_end;

  resp_array_stream_parser_top DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout),
    .cfg  (cfg)
  );

  resp_array_stream_parser_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .din           (din),
    .dout          (dout),
    .cfg           (cfg),
    .fail_count    (fail_count),
    .results_owed  (results_owed),
    .beats_checked (beats_checked),
    .records_done  (records_done)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result sink with random stalls
  initial begin
    int stall;
    dout.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) == 0) snk_burst = !snk_burst;
      stall = snk_burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        dout.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dout.ready <= 1'b1;
      @(posedge clk);
      while (!dout.valid) @(posedge clk);
    end
  end

  // one byte beat, after a random gap; valid stays high afterwards
  task automatic send_byte(input logic [BYTE_BITS-1:0] b);
    int gap;
    if ($urandom_range(0, 99) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      din.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din.valid     <= 1'b1;
    din.data_byte <= b;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // decimal, now and then with leading zeros
  task automatic send_decimal(input int unsigned value);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send_byte(CH_ZERO);
    send_text($sformatf("%0d", value));
  endtask

  // header line end, CR optional
  task automatic send_eol();
    if ($urandom_range(0, 1)) send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic send_payload(input int unsigned len);
    repeat (len) send_byte(BYTE_BITS'($urandom_range(0, 255)));
  endtask

  task automatic send_bulk_head(input int unsigned len);
    send_byte(CH_DOLLAR);
    send_decimal(len);
    send_eol();
  endtask

  // one bulk string within the length limit
  task automatic send_bulk();
    int unsigned len;
    len = $urandom_range(0, (lim_len > 16) ? 16 : lim_len);
    if (lim_len <= 48 && $urandom_range(0, 7) == 0) len = lim_len;
    send_bulk_head(len);
    send_payload(len);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // one record within the count limit, sometimes after a blank line
  task automatic send_record();
    int unsigned n;
    if ($urandom_range(0, 7) == 0) send_text("\r\n");
    n = $urandom_range(1, (lim_cnt > 6) ? 6 : lim_cnt);
    if (lim_cnt <= 12 && $urandom_range(0, 5) == 0) n = lim_cnt;
    send_byte(CH_STAR);
    send_decimal(n);
    send_eol();
    repeat (n) send_bulk();
  endtask

  // stop the byte stream and let every owed result drain
  task automatic settle();
    din.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input rasp_reg_t idx, input int unsigned value);
    settle();
    cfg.index <= idx;
    cfg.data  <= CFG_DATA_BITS'(value);
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic set_limits(input int unsigned cnt, input int unsigned len);
    write_reg(REG_MAX_ARG_COUNT, cnt);
    write_reg(REG_MAX_ARG_LENGTH, len);
    lim_cnt = cnt;
    lim_len = len;
  endtask

  // random byte outside a set, optionally no digits either
  function automatic logic [BYTE_BITS-1:0] stray_byte(input bit no_digits,
                                                      input logic [BYTE_BITS-1:0] a,
                                                      input logic [BYTE_BITS-1:0] b,
                                                      input logic [BYTE_BITS-1:0] c);
    logic [BYTE_BITS-1:0] x;
    do x = BYTE_BITS'($urandom_range(0, 255));
    while (x == a || x == b || x == c || (no_digits && x >= CH_ZERO && x <= CH_NINE));
    return x;
  endfunction

  // close the stream with a halt or one malformed sequence, then noise
  task automatic end_stream();
    int unsigned len;
    stream_end = ending_t'($urandom_range(0, int'(END_TERM_LF)));
    case (stream_end)
      END_HALT:       send_byte(CH_LF);
      END_BAD_RECORD: send_byte(stray_byte(1'b0, CH_STAR, CH_CR, CH_LF));
      END_BAD_BLANK: begin
        send_byte(CH_CR);
        send_byte(stray_byte(1'b0, CH_LF, CH_LF, CH_LF));
      end
      END_COUNT_ZERO: send_text("*0\r\n");
      END_COUNT_OVER: begin
        send_byte(CH_STAR);
        send_decimal(lim_cnt + 1);
        send_eol();
      end
      END_COUNT_CHAR: begin
        send_text("*1");
        send_byte(stray_byte(1'b1, CH_CR, CH_LF, CH_LF));
      end
      END_COUNT_EMPTY: send_text("*\n");
      END_COUNT_CR: begin
        send_text("*2\r");
        send_byte(stray_byte(1'b0, CH_LF, CH_LF, CH_LF));
      end
      END_COUNT_SAT: send_text("*999999999999\r\n");
      END_BAD_BULK: begin
        send_text("*1\r\n");
        send_byte(stray_byte(1'b0, CH_DOLLAR, CH_DOLLAR, CH_DOLLAR));
      end
      END_LEN_OVER: begin
        send_text("*1\n$");
        send_decimal(lim_len + 1);
        send_eol();
      end
      END_LEN_CHAR: begin
        send_text("*1\n$3");
        send_byte(stray_byte(1'b1, CH_CR, CH_LF, CH_LF));
      end
      END_LEN_EMPTY: send_text("*1\n$\r\n");
      END_LEN_CR: begin
        send_text("*1\n$0\r");
        send_byte(stray_byte(1'b0, CH_LF, CH_LF, CH_LF));
      end
      END_LEN_SAT: send_text("*1\n$99999999999\n");
      default: begin
        // payload, then a broken CR LF
        len = (lim_len < 3) ? lim_len : 3;
        send_text("*1\n");
        send_bulk_head(len);
        send_payload(len);
        if (stream_end == END_TERM_CHAR) begin
          send_byte(stray_byte(1'b0, CH_CR, CH_CR, CH_CR));
        end else begin
          send_byte(CH_CR);
          send_byte(stray_byte(1'b0, CH_LF, CH_LF, CH_LF));
        end
      end
    endcase
    // everything after must stay halted or in error
    repeat (16) send_byte(BYTE_BITS'($urandom_range(0, 255)));
  endtask

  // stimulus and verdict
  initial begin
    int phase_end;
    rst           <= 1'b1;
    din.valid     <= 1'b0;
    din.data_byte <= '0;
    cfg.valid     <= 1'b0;
    cfg.index     <= REG_MAX_ARG_COUNT;
    cfg.data      <= '0;
    lim_cnt = MAX_ARG_COUNT_RST;
    lim_len = MAX_ARG_LENGTH_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: blank line, empty single bulk, bare LF headers, byte extremes
    send_text("\r\n");
    send_text("*1\r\n$0\r\n\r\n");
    send_text("*2\n$1\n");
    send_byte(8'h00);
    send_text("\r\n$02\r\n");
    send_byte(8'hFF);
    send_byte(CH_LF);
    send_text("\r\n");

    // random records under reset limits, then under a series of settings
    phase_end = bytes_sent + PHASE_BYTES;
    while (bytes_sent < phase_end) send_record();
    for (int ph = 1; bytes_sent < RANDOM_BYTES; ph++) begin
      case (ph % 3)
        1: set_limits(1, 0);
        2: set_limits(MAX_ARG_COUNT_RST, MAX_ARG_LENGTH_RST);
        default: set_limits(($urandom_range(0, 3) == 0) ? $urandom_range(1, 10000)
                                                        : $urandom_range(1, 8),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1048576)
                                                        : $urandom_range(0, 24));
      endcase
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) send_record();
    end

    end_stream();
    din.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes over %0d register writes, %0d records closed",
             bytes_sent, reg_writes, records_done);
    $display("checked %0d result beats, stream closed by %s",
             beats_checked, stream_end.name());
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
